### rtl/core/crfl_pkg.sv
// crfl_pkg: shared constants and types for the replacement cache
// no dependencies
`timescale 1ns / 1ps
package crfl_pkg;
    localparam int MaxEntries = 64;
    localparam int IdxW = $clog2(MaxEntries);
    localparam int CapW = 7;
    localparam logic [1:0] POL_FIFO  = 2'd0;
    localparam logic [1:0] POL_LRU   = 2'd1;
    localparam logic [1:0] POL_CLOCK = 2'd2;
    localparam logic [1:0] KIND_HIT  = 2'd0;
    localparam logic [1:0] KIND_COMP = 2'd1;
    localparam logic [1:0] KIND_CAP  = 2'd2;
    localparam logic [0:0] REG_CAPACITY = 1'b0;
    localparam logic [0:0] REG_POLICY   = 1'b1;

    // per-cell command from the controller
    typedef struct packed {
        logic       shift;      // cells from shift_from up to last-1 take neighbor value
        logic [IdxW-1:0] shift_from;
        logic [IdxW-1:0] last;  // last slot in use
        logic       wr;         // write key at wr_idx
        logic [IdxW-1:0] wr_idx;
        logic [7:0] wr_key;
        logic       wr_ref;
        logic       set_ref;    // set ref bit at ref_idx
        logic       clr_ref;    // clear ref bit at ref_idx
        logic [IdxW-1:0] ref_idx;
    } crfl_cmd_t;
endpackage

### rtl/core/crfl_cell.sv
// crfl_cell: one cache slot holding key and reference bit, with compare
// depends on crfl_pkg
`timescale 1ns / 1ps
module crfl_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [crfl_pkg::IdxW-1:0] idx,
    input  crfl_pkg::crfl_cmd_t  cmd,
    input  logic [7:0]           probe_key,
    input  logic [7:0]           nbr_key,
    input  logic                 nbr_ref,
    output logic [7:0]           key,
    output logic                 refb,
    output logic                 match
);
    import crfl_pkg::*;
    logic [7:0] key_reg, key_next;
    logic       ref_reg, ref_next;

    // next value: write, neighbor shift, or ref update
    always_comb begin
        key_next = key_reg;
        ref_next = ref_reg;
        if (cmd.shift && idx >= cmd.shift_from && idx < cmd.last) begin
            key_next = nbr_key;
            ref_next = nbr_ref;
        end
        if (cmd.set_ref && idx == cmd.ref_idx) ref_next = 1'b1;
        if (cmd.clr_ref && idx == cmd.ref_idx) ref_next = 1'b0;
        if (cmd.wr && idx == cmd.wr_idx) begin
            key_next = cmd.wr_key;
            ref_next = cmd.wr_ref;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= '0;
            ref_reg <= 1'b0;
        end else begin
            key_reg <= key_next;
            ref_reg <= ref_next;
        end
    end

    assign key   = key_reg;
    assign refb  = ref_reg;
    assign match = (key_reg == probe_key) && (idx <= cmd.last);
endmodule

### rtl/core/cache_replacement_fifo_lru_clock.sv
// Replacement cache top: a request passes through the lookup and sweep states to the result (FIFO, LRU, clock hit);
// the reserved key zero skips the sweep; a clock miss stays in sweep while the hand's reference bit is set.
// One access at a time: the next request is taken only after the result is accepted.
// Synchronous active-low reset clears all slots, seen map and counters at once.
// Depends on crfl_pkg, crfl_cell
`timescale 1ns / 1ps
module cache_replacement_fifo_lru_clock (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] key_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [0] hit, [2:1] miss_kind, [34:3] compulsory_total,
                                   // [66:35] capacity_total, rest zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [6:0]  cfg_data
);
    import crfl_pkg::*;
    typedef enum logic [1:0] {S_IDLE, S_LOOK, S_SWEEP, S_OUT} state_t;

    state_t          state_reg;
    logic [CapW-1:0] cap_reg;
    logic [1:0]      pol_reg;
    logic [7:0]      key_reg;
    logic [IdxW-1:0] hand_reg;
    logic [255:0]    seen_reg;
    logic [31:0]     comp_reg, capc_reg;
    logic            hit_reg;
    logic [1:0]      kind_reg;
    logic            found_reg;
    logic [IdxW-1:0] pos_reg;

    logic [7:0]      keys [MaxEntries];
    logic            refs [MaxEntries];
    logic [MaxEntries-1:0] match;
    crfl_cmd_t       cmd;

    // effective size and policy
    logic [IdxW-1:0] last;
    logic [1:0]      pol;
    always_comb begin
        if (cap_reg == '0) last = '0;
        else if (cap_reg > CapW'(MaxEntries)) last = IdxW'(MaxEntries - 1);
        else last = IdxW'(cap_reg - 1'b1);
        pol = (pol_reg == 2'd3) ? POL_FIFO : pol_reg;
    end
    logic [IdxW-1:0] hand_eff, hand_inc;
    assign hand_eff = (hand_reg > last) ? '0 : hand_reg;
    assign hand_inc = (hand_eff == last) ? '0 : hand_eff + 1'b1;

    // chain of slot cells
    for (genvar g = 0; g < MaxEntries; g++) begin : g_cell
        crfl_cell u_cell (
            .aclk, .aresetn, .idx(IdxW'(g)), .cmd, .probe_key(key_reg),
            .nbr_key(keys[(g + 1) % MaxEntries]), .nbr_ref(refs[(g + 1) % MaxEntries]),
            .key(keys[g]), .refb(refs[g]), .match(match[g])
        );
    end

    // priority encode of compare results, registered
    logic            found;
    logic [IdxW-1:0] pos;
    always_comb begin
        found = 1'b0;
        pos = '0;
        for (int i = MaxEntries - 1; i >= 0; i--)
            if (match[i]) begin found = 1'b1; pos = IdxW'(i); end
    end

    // slot commands
    always_comb begin
        cmd = '0;
        cmd.last = last;
        cmd.wr_key = key_reg;
        if (state_reg == S_SWEEP) begin
            if (found_reg) begin
                if (pol == POL_LRU) begin
                    cmd.shift = 1'b1; cmd.shift_from = pos_reg;
                    cmd.wr = 1'b1; cmd.wr_idx = last; cmd.wr_ref = refs[pos_reg];
                end else if (pol == POL_CLOCK) begin
                    cmd.set_ref = 1'b1; cmd.ref_idx = pos_reg;
                end
            end else if (pol == POL_LRU) begin
                cmd.shift = 1'b1; cmd.shift_from = '0;
                cmd.wr = 1'b1; cmd.wr_idx = last; cmd.wr_ref = refs[0];
            end else if (pol == POL_CLOCK && refs[hand_eff]) begin
                cmd.clr_ref = 1'b1; cmd.ref_idx = hand_eff;
            end else begin
                cmd.wr = 1'b1; cmd.wr_idx = hand_eff; cmd.wr_ref = 1'b0;
            end
        end
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = (state_reg == S_OUT);
    assign m_tdata   = {5'd0, capc_reg, comp_reg, kind_reg, hit_reg};

    // sequencer, counters and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cap_reg <= CapW'(3);
            pol_reg <= POL_FIFO;
            hand_reg <= '0;
            seen_reg <= '0;
            comp_reg <= '0;
            capc_reg <= '0;
            hit_reg <= 1'b0;
            kind_reg <= KIND_HIT;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == REG_CAPACITY) cap_reg <= cfg_data;
                else pol_reg <= cfg_data[1:0];
            end
            case (state_reg)
                S_IDLE: if (s_tvalid) begin
                    key_reg <= s_tdata;
                    state_reg <= S_LOOK;
                end
                S_LOOK: begin
                    found_reg <= found;
                    pos_reg <= pos;
                    hand_reg <= hand_eff;
                    if (key_reg == 8'd0) begin
                        hit_reg <= 1'b0; kind_reg <= KIND_HIT; state_reg <= S_OUT;
                    end else begin
                        hit_reg <= found;
                        if (found) kind_reg <= KIND_HIT;
                        else if (!seen_reg[key_reg]) begin
                            kind_reg <= KIND_COMP;
                            seen_reg[key_reg] <= 1'b1;
                            if (comp_reg != '1) comp_reg <= comp_reg + 1'b1;
                        end else begin
                            kind_reg <= KIND_CAP;
                            if (capc_reg != '1) capc_reg <= capc_reg + 1'b1;
                        end
                        state_reg <= S_SWEEP;
                    end
                end
                S_SWEEP: begin
                    if (found_reg || pol == POL_LRU) state_reg <= S_OUT;
                    else begin
                        hand_reg <= hand_inc;
                        if (!(pol == POL_CLOCK && refs[hand_eff])) state_reg <= S_OUT;
                    end
                end
                S_OUT: if (m_tready) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

### rtl/core/crfl_checker.sv
// crfl_checker: port-level assertions for the replacement cache
// bound to cache_replacement_fifo_lru_clock; depends on nothing else
`timescale 1ns / 1ps
module crfl_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[2:1] != 2'd3 && !(m_tdata[0] && m_tdata[2:1] != 2'd0))
        else $error("bad miss kind");
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("request taken while result pending");
    // one access at a time: input closes right after a request is taken
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready) else $error("second request taken while busy");
endmodule

bind cache_replacement_fifo_lru_clock crfl_checker u_crfl_checker (
    .aclk, .aresetn, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata
);

### test/cache_replacement_fifo_lru_clock_test.sv
// cache_replacement_fifo_lru_clock_test: drives key requests through the replacement cache
// under each policy and capacity, predicts hit, miss kind and totals, checks every result
// depends on crfl_pkg and cache_replacement_fifo_lru_clock
`timescale 1ns / 1ps
module cache_replacement_fifo_lru_clock_test;
    import crfl_pkg::*;

    typedef struct packed {
        logic [31:0] cap_total;
        logic [31:0] comp_total;
        logic [1:0]  kind;
        logic        hit;
    } access_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [7:0] key_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;    // [0] hit, [2:1] miss_kind, [34:3] compulsory_total,
                             // [66:35] capacity_total, rest zero
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_index;
    logic [6:0]  cfg_data;

    cache_replacement_fifo_lru_clock uut (.*);

    // predictor state
    logic [7:0]  pk_keys [MaxEntries];
    logic        pk_ref [MaxEntries];
    logic [5:0]  pk_hand;
    logic        pk_seen [256];
    logic [31:0] pk_comp;
    logic [31:0] pk_capm;
    logic [6:0]  pk_capacity;
    logic [1:0]  pk_policy;

    logic [7:0]     key_queue[$];
    access_result_t result_queue[$];
    int  error_count;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  hold_cycles;
    int  phase_num;
    bit  hold_done;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // shift slots pos+1..n-1 down, put key at the last slot in use
    function automatic void move_to_last(input int pos, input int n, input logic [7:0] k);
        logic r;
        r = pk_ref[pos];
        for (int i = pos; i + 1 < n; i++) begin
            pk_keys[i] = pk_keys[i + 1];
            pk_ref[i] = pk_ref[i + 1];
        end
        pk_keys[n - 1] = k;
        pk_ref[n - 1] = r;
    endfunction

    function automatic access_result_t predict_access(input logic [7:0] k);
        access_result_t res;
        int n;
        int pos;
        logic [1:0] pol;
        n = (pk_capacity == 0) ? 1 : (pk_capacity > MaxEntries) ? MaxEntries : pk_capacity;
        pol = (pk_policy == 2'd3) ? POL_FIFO : pk_policy;
        if (pk_hand >= n) pk_hand = '0;
        res = '0;
        res.kind = KIND_HIT;
        if (k != 0) begin
            pos = -1;
            for (int i = 0; i < n; i++)
                if (pos < 0 && pk_keys[i] == k) pos = i;
            if (pos >= 0) begin
                res.hit = 1'b1;
                if (pol == POL_LRU) move_to_last(pos, n, k);
                else if (pol == POL_CLOCK) pk_ref[pos] = 1'b1;
            end else begin
                if (!pk_seen[k]) begin
                    pk_seen[k] = 1'b1;
                    res.kind = KIND_COMP;
                    if (pk_comp != 32'hFFFF_FFFF) pk_comp++;
                end else begin
                    res.kind = KIND_CAP;
                    if (pk_capm != 32'hFFFF_FFFF) pk_capm++;
                end
                if (pol == POL_LRU) begin
                    move_to_last(0, n, k);
                end else begin
                    if (pol == POL_CLOCK)
                        while (pk_ref[pk_hand]) begin
                            pk_ref[pk_hand] = 1'b0;
                            pk_hand = 6'((pk_hand + 1) % n);
                        end
                    pk_keys[pk_hand] = k;
                    pk_ref[pk_hand] = 1'b0;
                    pk_hand = 6'((pk_hand + 1) % n);
                end
            end
        end
        res.comp_total = pk_comp;
        res.cap_total = pk_capm;
        return res;
    endfunction

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // driver: offers queued keys, predicts on acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                result_queue.push_back(predict_access(s_tdata));
                void'(key_queue.pop_front());
            end
            if (s_tvalid && !s_tready) begin
                s_tvalid <= 1'b1;
            end else if (key_queue.size() > 0 &&
                         $urandom_range(99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata <= key_queue[0];
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // long receiver hold, counted in its own process
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_cycles <= 0;
            hold_done <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
        end else if (phase_num == 5 && !hold_done) begin
            hold_cycles <= 300;
            hold_done <= 1'b1;
        end
    end

    // monitor and receiver stall
    always @(posedge aclk) begin
        access_result_t got;
        access_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = access_result_t'(m_tdata[66:0]);
                if (result_queue.size() == 0) begin
                    report_mismatch("unexpected result", 32'(got.kind), 32'd0);
                end else begin
                    want = result_queue.pop_front();
                    if (got.hit !== want.hit)
                        report_mismatch("hit", 32'(got.hit), 32'(want.hit));
                    if (got.kind !== want.kind)
                        report_mismatch("miss_kind", 32'(got.kind), 32'(want.kind));
                    if (got.comp_total !== want.comp_total)
                        report_mismatch("compulsory_total", got.comp_total, want.comp_total);
                    if (got.cap_total !== want.cap_total)
                        report_mismatch("capacity_total", got.cap_total, want.cap_total);
                end
                if (m_tdata[71:67] !== '0)
                    report_mismatch("pad bits", 32'(m_tdata[71:67]), 32'd0);
            end
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic write_reg(input logic [0:0] idx, input logic [6:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_CAPACITY) pk_capacity = val;
        else pk_policy = val[1:0];
    endtask

    task automatic drain();
        while (key_queue.size() != 0 || result_queue.size() != 0 || s_tvalid)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // well-formed traffic: keys from a small working set, some noise keys
    task automatic push_random(input int count, input int spread);
        for (int i = 0; i < count; i++)
            if ($urandom_range(9) == 0) key_queue.push_back(8'($urandom_range(255, 1)));
            else key_queue.push_back(8'($urandom_range(spread, 1)));
    endtask

    initial begin
        logic [6:0] caps [6];
        caps = '{7'd1, 7'd2, 7'd5, 7'd64, 7'd0, 7'd127};
        error_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        phase_num = -1;
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        for (int i = 0; i < MaxEntries; i++) begin
            pk_keys[i] = '0;
            pk_ref[i] = 1'b0;
        end
        for (int i = 0; i < 256; i++) pk_seen[i] = 1'b0;
        pk_hand = '0;
        pk_comp = '0;
        pk_capm = '0;
        pk_capacity = 7'd3;
        pk_policy = POL_FIFO;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset config, reserved key, extremes, repeats; then clock and LRU policies
        key_queue = '{8'd1, 8'd255, 8'd0, 8'd1, 8'd128, 8'd127, 8'd255, 8'd1, 8'd2,
                      8'd85, 8'd170, 8'd1};
        drain();
        write_reg(REG_POLICY, {5'd0, POL_CLOCK});
        key_queue = '{8'd1, 8'd2, 8'd1, 8'd3, 8'd2, 8'd4, 8'd5, 8'd1, 8'd0};
        drain();
        write_reg(REG_POLICY, {5'd0, POL_LRU});
        key_queue = '{8'd1, 8'd2, 8'd4, 8'd1, 8'd6, 8'd2};
        drain();

        // random phases across policies, capacities and idling
        for (int ph = 0; ph < 24; ph++) begin
            phase_num = ph;
            write_reg(REG_CAPACITY, caps[ph % 6]);
            write_reg(REG_POLICY, 7'(ph % 4));
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            push_random(75, (caps[ph % 6] < 8) ? 8 : 90);
            drain();
        end

        if (error_count == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

    // run limit
    initial begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end
endmodule
